// ===== rtl/tlps_pkg.sv =====
`timescale 1ns / 1ps
// Package for the two-level preemptive scheduler core.
// Holds queue sizing, the sequencer state type and the result status codes.
// No dependencies.
package tlps_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W     = 32;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARRIVE,
        S_PREEMPT,
        S_SELECT,
        S_LOAD,
        S_RUN,
        S_DONE
    } seq_state_t;

    typedef enum logic [2:0] {
        RES_QUEUED    = 3'd0,
        RES_DROPPED   = 3'd1,
        RES_IDLE      = 3'd2,
        RES_RAN       = 3'd3,
        RES_COMPLETED = 3'd4
    } res_status_t;

    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Advance a ring pointer with wrap at the queue depth.
    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

endpackage

// ===== rtl/tlps_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Used for both job queues; no package dependency.
module tlps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/two_level_preemptive_scheduler_core.sv =====
`timescale 1ns / 1ps
// Two-level preemptive scheduler: system and user ring queues in RAM, one running job.
// An arrival steps through ARRIVE then DONE; a tick through PREEMPT, SELECT and DONE when idle,
// adding RUN when a job keeps running, and LOAD then RUN when a job is loaded from a queue
// (RAM read in SELECT, then load). One item at a time: a new item is taken only in S_IDLE; a
// result not yet taken holds the sequencer in its last step. Reset clears the queue pointers, the
// running job and the tick count; queue RAM contents are left as they are and need no clearing pass.
module two_level_preemptive_scheduler_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] job_id, [31:16] burst_len
    input  logic [1:0]  s_axis_tuser,   // [0] op, [1] is_system
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] out_job_id, [47:16] tick_count
    output logic [2:0]  m_axis_tuser    // [2:0] status
);
    import tlps_pkg::*;

    seq_state_t  state_reg, state_next;

    // Latched input item
    logic        sys_in_reg;
    logic [15:0] id_in_reg;
    logic [15:0] burst_in_reg;

    // Queue pointers
    ptr_t sys_head_reg, sys_head_next, sys_tail_reg, sys_tail_next;
    cnt_t sys_cnt_reg, sys_cnt_next;
    ptr_t usr_head_reg, usr_head_next, usr_tail_reg, usr_tail_next;
    cnt_t usr_cnt_reg, usr_cnt_next;

    // Running job
    logic        run_valid_reg, run_valid_next;
    logic        run_sys_reg, run_sys_next;
    logic [15:0] run_id_reg, run_id_next;
    logic [15:0] run_left_reg, run_left_next;
    logic        sel_sys_reg, sel_sys_next;

    logic [31:0] tick_reg, tick_next;

    res_status_t res_status_reg, res_status_next;
    logic [15:0] res_id_reg, res_id_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [47:0] out_data_reg, out_data_next;
    logic [2:0]  out_user_reg, out_user_next;

    // RAM controls
    logic                 sys_we, usr_we, sys_re, usr_re;
    ptr_t                 usr_waddr;
    logic [ENTRY_W-1:0]   usr_wdata, sys_rdata, usr_rdata;

    logic in_xfer;
    logic out_free;
    logic sys_full, usr_full, sys_empty, usr_empty;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign sys_full  = (sys_cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign usr_full  = (usr_cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign sys_empty = (sys_cnt_reg == '0);
    assign usr_empty = (usr_cnt_reg == '0);

    tlps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_sys_ram (
        .clk   (clk),
        .we    (sys_we),
        .waddr (sys_tail_reg),
        .wdata ({burst_in_reg, id_in_reg}),
        .re    (sys_re),
        .raddr (sys_head_reg),
        .rdata (sys_rdata)
    );

    tlps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_usr_ram (
        .clk   (clk),
        .we    (usr_we),
        .waddr (usr_waddr),
        .wdata (usr_wdata),
        .re    (usr_re),
        .raddr (usr_head_reg),
        .rdata (usr_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                    state_next = (s_axis_tuser[0] == OP_TICK) ? S_PREEMPT : S_ARRIVE;
            end
            S_ARRIVE:  state_next = S_DONE;
            S_PREEMPT: state_next = S_SELECT;
            S_SELECT:
            begin
                if (run_valid_reg)
                    state_next = S_RUN;
                else if (!sys_empty || !usr_empty)
                    state_next = S_LOAD;
                else
                    state_next = S_DONE;
            end
            S_LOAD: state_next = S_RUN;
            S_RUN:  state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and RAM controls
    always_comb
    begin
        sys_head_next   = sys_head_reg;
        sys_tail_next   = sys_tail_reg;
        sys_cnt_next    = sys_cnt_reg;
        usr_head_next   = usr_head_reg;
        usr_tail_next   = usr_tail_reg;
        usr_cnt_next    = usr_cnt_reg;
        run_valid_next  = run_valid_reg;
        run_sys_next    = run_sys_reg;
        run_id_next     = run_id_reg;
        run_left_next   = run_left_reg;
        sel_sys_next    = sel_sys_reg;
        tick_next       = tick_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        sys_we          = 1'b0;
        usr_we          = 1'b0;
        sys_re          = 1'b0;
        usr_re          = 1'b0;
        usr_waddr       = usr_tail_reg;
        usr_wdata       = {burst_in_reg, id_in_reg};

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_ARRIVE:
            begin
                res_id_next = id_in_reg;
                if (sys_in_reg)
                begin
                    if (sys_full)
                        res_status_next = RES_DROPPED;
                    else
                    begin
                        sys_we          = 1'b1;
                        sys_tail_next   = ptr_inc(sys_tail_reg);
                        sys_cnt_next    = sys_cnt_reg + CNT_W'(1);
                        res_status_next = RES_QUEUED;
                    end
                end
                else
                begin
                    if (usr_full)
                        res_status_next = RES_DROPPED;
                    else
                    begin
                        usr_we          = 1'b1;
                        usr_tail_next   = ptr_inc(usr_tail_reg);
                        usr_cnt_next    = usr_cnt_reg + CNT_W'(1);
                        res_status_next = RES_QUEUED;
                    end
                end
            end
            S_PREEMPT:
            begin
                tick_next = tick_reg + 32'd1;
                // Push a running user job back when system work waits; defer if no room
                if (run_valid_reg && !run_sys_reg && !sys_empty && !usr_full)
                begin
                    usr_we         = 1'b1;
                    usr_wdata      = {run_left_reg, run_id_reg};
                    usr_tail_next  = ptr_inc(usr_tail_reg);
                    usr_cnt_next   = usr_cnt_reg + CNT_W'(1);
                    run_valid_next = 1'b0;
                end
            end
            S_SELECT:
            begin
                if (!run_valid_reg)
                begin
                    if (!sys_empty)
                    begin
                        sys_re        = 1'b1;
                        sys_head_next = ptr_inc(sys_head_reg);
                        sys_cnt_next  = sys_cnt_reg - CNT_W'(1);
                        sel_sys_next  = 1'b1;
                    end
                    else if (!usr_empty)
                    begin
                        usr_re        = 1'b1;
                        usr_head_next = ptr_inc(usr_head_reg);
                        usr_cnt_next  = usr_cnt_reg - CNT_W'(1);
                        sel_sys_next  = 1'b0;
                    end
                    else
                    begin
                        res_status_next = RES_IDLE;
                        res_id_next     = '0;
                    end
                end
            end
            S_LOAD:
            begin
                run_valid_next = 1'b1;
                run_sys_next   = sel_sys_reg;
                if (sel_sys_reg)
                begin
                    run_id_next   = sys_rdata[15:0];
                    run_left_next = sys_rdata[31:16];
                end
                else
                begin
                    run_id_next   = usr_rdata[15:0];
                    run_left_next = usr_rdata[31:16];
                end
            end
            S_RUN:
            begin
                res_id_next = run_id_reg;
                if (run_left_reg <= 16'd1)
                begin
                    run_left_next   = '0;
                    run_valid_next  = 1'b0;
                    res_status_next = RES_COMPLETED;
                end
                else
                begin
                    run_left_next   = run_left_reg - 16'd1;
                    res_status_next = RES_RAN;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {tick_reg, res_id_reg};
                    out_user_next  = res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sys_head_reg  <= '0;
            sys_tail_reg  <= '0;
            sys_cnt_reg   <= '0;
            usr_head_reg  <= '0;
            usr_tail_reg  <= '0;
            usr_cnt_reg   <= '0;
            run_valid_reg <= 1'b0;
            run_sys_reg   <= 1'b0;
            run_id_reg    <= '0;
            run_left_reg  <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sys_head_reg  <= sys_head_next;
            sys_tail_reg  <= sys_tail_next;
            sys_cnt_reg   <= sys_cnt_next;
            usr_head_reg  <= usr_head_next;
            usr_tail_reg  <= usr_tail_next;
            usr_cnt_reg   <= usr_cnt_next;
            run_valid_reg <= run_valid_next;
            run_sys_reg   <= run_sys_next;
            run_id_reg    <= run_id_next;
            run_left_reg  <= run_left_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            sys_in_reg   <= s_axis_tuser[1];
            id_in_reg    <= s_axis_tdata[15:0];
            burst_in_reg <= s_axis_tdata[31:16];
        end
        sel_sys_reg    <= sel_sys_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        out_data_reg   <= out_data_next;
        out_user_reg   <= out_user_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule
